// File: hdl/bitmap_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Concurrent checks clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared types and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = 5;
  localparam int RESERVED_TAIL = 4;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_MOD,
    S_DONE
  } bba_state_t;

endpackage

`default_nettype wire

// File: hdl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a pool of fixed-size blocks, one used bit each.
// ----------------------------------------------------------------------------
// The used bits live in a memory of 32-bit rows; a flip-flop per row tells
// whether that row still has a free block, so an allocate picks its row at
// once and finds the bit in the row read back. One item is in work at a time.
// An allocate or an in-range free goes through accept, memory read, update
// and write back, and result; an allocate on a full pool or a free of an
// out-of-range index goes from accept straight to result. The result
// register lets the next item be taken while a result waits. After reset a
// clearing pass loads every row, marking the last four blocks used; no item
// is accepted during it.
`default_nettype none

module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [9:0] block_index, [15:10] zero
  input  wire logic        s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [9:0] granted_index, [20:10] used_count, [23:21] zero
  output logic             m_tuser    // status
);

  localparam int ROWS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  bba_state_t state, state_next;

  logic [WORD_BITS-1:0] mem [ROWS];
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] init_word;
  logic [WORD_BITS-1:0] set_mask;
  logic [WORD_BITS-1:0] mod_word;
  logic [ROWS-1:0]      row_free;
  logic [RW-1:0]        init_row;
  logic [RW-1:0]        op_row;
  logic [RW-1:0]        first_row;
  logic [RW-1:0]        free_row;
  logic [BIT_W-1:0]     op_bit;
  logic [BIT_W-1:0]     first_bit;
  logic [RW+BIT_W-1:0]  gidx;
  logic                 op_alloc;
  logic                 any_free;
  logic                 in_range;
  logic                 free_hit;
  logic                 accept;
  logic                 out_load;
  logic                 res_full;
  logic [IDX_W-1:0]     res_idx;
  logic [CNT_W-1:0]     used_total;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      init_word[b] = (int'(init_row) * WORD_BITS + b) >= (NUM_BLOCKS - RESERVED_TAIL);
    end
  end

  always_comb begin
    first_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (row_free[r]) begin
        first_row = RW'(r);
      end
    end
  end

  always_comb begin
    first_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!rd_data[b]) begin
        first_bit = BIT_W'(b);
      end
    end
  end

  assign any_free = |row_free;
  assign free_row = RW'(s_tdata[IDX_W-1:0] >> BIT_W);
  assign in_range = {22'd0, s_tdata[IDX_W-1:0]} < 32'(NUM_BLOCKS);
  assign set_mask = WORD_BITS'(1) << (op_alloc ? first_bit : op_bit);
  assign mod_word = op_alloc ? (rd_data | set_mask) : (rd_data & ~set_mask);
  assign free_hit = rd_data[op_bit];
  assign gidx     = {op_row, first_bit};

  always_comb begin
    state_next = state;
    s_tready   = (state == S_IDLE);
    accept     = s_tvalid && s_tready;
    out_load   = (state == S_DONE) && (!m_tvalid || m_tready);
    case (state)
      S_INIT: begin
        if (init_row == RW'(ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == ACT_ALLOC) begin
            state_next = any_free ? S_READ : S_DONE;
          end else begin
            state_next = in_range ? S_READ : S_DONE;
          end
        end
      end
      S_READ: state_next = S_MOD;
      S_MOD:  state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_row   <= '0;
      row_free   <= '0;
      used_total <= CNT_W'(RESERVED_TAIL);
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        init_row           <= init_row + RW'(1);
        row_free[init_row] <= ~&init_word;
      end
      if (state == S_MOD) begin
        if (op_alloc) begin
          row_free[op_row] <= ~&mod_word;
          used_total       <= used_total + CNT_W'(1);
        end else if (free_hit) begin
          row_free[op_row] <= 1'b1;
          used_total       <= used_total - CNT_W'(1);
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_alloc <= (s_tuser == ACT_ALLOC);
      op_row   <= (s_tuser == ACT_ALLOC) ? first_row : free_row;
      op_bit   <= s_tdata[BIT_W-1:0];
      res_idx  <= '0;
      res_full <= (s_tuser == ACT_ALLOC) && !any_free;
    end
    if (state == S_MOD && op_alloc) begin
      res_idx <= IDX_W'(gidx);
    end
    if (out_load) begin
      m_tdata <= {3'b000, used_total, res_idx};
      m_tuser <= res_full;
    end
  end

  // bitmap rows: one write port, registered read
  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      mem[init_row] <= init_word;
    end else if (state == S_MOD) begin
      mem[op_row] <= mod_word;
    end
    if (state == S_READ) begin
      rd_data <= mem[op_row];
    end
  end

`include "bitmap_block_allocator_macros.svh"

  `BBA_ASSERT_NOW(a_row_has_free, (state == S_MOD) && op_alloc, rd_data != '1, "row summary says free but row is full")
  `BBA_ASSERT_NEXT(a_full_skips_mem, accept && (s_tuser == ACT_ALLOC) && !any_free, (state == S_DONE) && res_full, "full allocate not reported")
  `BBA_ASSERT_NEXT(a_done_loads, (state == S_DONE) && !m_tvalid, m_tvalid, "result not presented")
  `BBA_ASSERT_NEXT(a_mod_to_done, state == S_MOD, state == S_DONE, "update did not finish")

endmodule

`default_nettype wire

// File: tb/bba_checker.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Watches both item channels. It keeps its own copy of the used bitmap and
// the used count, works out the expected result of every accepted request,
// and compares each accepted result field by field with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_checker
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,   // [9:0] block_index, [15:10] zero
  input  wire logic        s_tuser,   // action
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,   // [9:0] granted_index, [20:10] used_count, [23:21] zero
  input  wire logic        m_tuser,   // status
  output int               fail_count,
  output int               pending,
  output int               pool_full_seen
);

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    logic             status;
    logic [CNT_W-1:0] used_count;
  } alloc_result_t;

  bit               used_map [NUM_BLOCKS];
  logic [CNT_W-1:0] used_total;
  alloc_result_t    expected_grants [$];

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    int            idx;
    bit            found;
    if (rst) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        used_map[i] = (i >= NUM_BLOCKS - RESERVED_TAIL);
      end
      used_total = CNT_W'(RESERVED_TAIL);
      expected_grants.delete();
      fail_count     = 0;
      pool_full_seen = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.granted_index = m_tdata[IDX_W-1:0];
        got.status        = m_tuser;
        got.used_count    = m_tdata[IDX_W +: CNT_W];
        if (got.status == ST_FULL) pool_full_seen++;
        if (expected_grants.size() == 0) begin
          $error("result with no request outstanding: granted_index %0d status %0d used_count %0d",
                 got.granted_index, got.status, got.used_count);
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          if (got.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, actual %0d", want.granted_index,
                   got.granted_index);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
          end
          if (got.used_count !== want.used_count) begin
            $error("used_count: expected %0d, actual %0d", want.used_count, got.used_count);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want  = '0;
        found = 1'b0;
        if (s_tuser == ACT_ALLOC) begin
          // first fit: lowest clear flag wins
          for (int i = 0; i < NUM_BLOCKS && !found; i++) begin
            if (!used_map[i]) begin
              used_map[i]        = 1'b1;
              used_total         = used_total + CNT_W'(1);
              want.granted_index = IDX_W'(i);
              found              = 1'b1;
            end
          end
          want.status = found ? ST_OK : ST_FULL;
        end else begin
          idx = int'(s_tdata[IDX_W-1:0]);
          if (idx < NUM_BLOCKS && used_map[idx]) begin
            used_map[idx] = 1'b0;
            used_total    = used_total - CNT_W'(1);
          end
          want.status = ST_OK;
        end
        want.used_count = used_total;
        expected_grants.push_back(want);
      end
    end
    pending = expected_grants.size();
  end

endmodule

// File: tb/tb_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate and free items with random gaps and result stalls: a short
// directed opening, a mixed phase, a fill to the pool-full state under a long
// output hold, and a drain that also frees the reserved tail blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_block_allocator
  import bba_pkg::*;
;

  localparam int NUM_BLOCKS  = 1024;
  localparam int HOLD_CYCLES = 250;
  localparam int IDLE_LIMIT  = 4000;
  localparam int FILL_ROUNDS = 40;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata  = '0;
  logic        s_tuser  = ACT_ALLOC;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;
  logic        m_tuser;

  int fail_count;
  int pending;
  int pool_full_seen;

  bit no_idle      = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;
  int alloc_sent   = 0;
  int free_sent    = 0;
  int last_used    = RESERVED_TAIL;
  int peak_used    = RESERVED_TAIL;
  int idle_cycles  = 0;
  int fill_rounds  = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  bitmap_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  bba_checker #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .fail_count     (fail_count),
    .pending        (pending),
    .pool_full_seen (pool_full_seen)
  );

  // entered and left at a falling edge
  task automatic send_request(input logic act, input logic [IDX_W-1:0] idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{(16-IDX_W){1'b0}}, idx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (act == ACT_ALLOC) alloc_sent++;
    else free_sent++;
  endtask

  // first fit packs used blocks low, so most frees land on a used block
  function automatic logic [IDX_W-1:0] pick_free_index();
    int r;
    int top;
    r   = $urandom_range(0, 9);
    top = (last_used + 4 > NUM_BLOCKS - 1) ? NUM_BLOCKS - 1 : last_used + 4;
    if (r < 7) return IDX_W'($urandom_range(0, top));
    if (r < 8) return IDX_W'($urandom_range(NUM_BLOCKS - 8, NUM_BLOCKS - 1));
    return IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
  endfunction

  task automatic run_mix(input int count, input int alloc_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < alloc_pct)
        send_request(ACT_ALLOC, IDX_W'($urandom_range(0, NUM_BLOCKS - 1)));
      else
        send_request(ACT_FREE, pick_free_index());
    end
  endtask

  // result side
  initial begin
    int stall;
    forever begin
      if (hold_request && !hold_done) begin
        m_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_done = 1'b1;
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      last_used = int'(m_tdata[IDX_W +: CNT_W]);
      if (last_used > peak_used) peak_used = last_used;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed opening; index field is don't-care on allocate
    send_request(ACT_ALLOC, 10'h3FF);
    send_request(ACT_ALLOC, 10'h000);
    send_request(ACT_ALLOC, 10'h2AA);
    send_request(ACT_FREE, 10'd1);
    send_request(ACT_ALLOC, 10'h155);
    send_request(ACT_FREE, 10'd5);        // already free
    send_request(ACT_FREE, 10'd1023);     // reserved tail block
    send_request(ACT_FREE, 10'd1020);
    send_request(ACT_ALLOC, 10'd0);
    send_request(ACT_ALLOC, 10'd0);
    send_request(ACT_FREE, 10'd0);
    send_request(ACT_FREE, 10'd1023);     // freed twice
    send_request(ACT_FREE, 10'h2AA);
    send_request(ACT_FREE, 10'h155);
    send_request(ACT_FREE, 10'd512);
    send_request(ACT_FREE, 10'd2);
    send_request(ACT_ALLOC, 10'h3FF);
    send_request(ACT_ALLOC, 10'h200);

    run_mix(300, 60);

    // fill the pool; the output is held off once while items keep coming
    hold_request = 1'b1;
    while (pool_full_seen < 24 && fill_rounds < FILL_ROUNDS) begin
      run_mix(50, 92);
      fill_rounds++;
    end

    // drain, first without idling
    no_idle = 1'b1;
    run_mix(150, 30);
    no_idle = 1'b0;
    run_mix(250, 25);
    run_mix(60, 80);

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d allocate and %0d free items, %0d pool-full results,",
             alloc_sent, free_sent, pool_full_seen);
    $display("peak used count %0d, with a %0d-cycle output hold.", peak_used, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/bba_pkg.sv
hdl/bitmap_block_allocator.sv
tb/bba_checker.sv
tb/tb_bitmap_block_allocator.sv
